// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define PPDC_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PPDC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/ppdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppdc_pkg
// types and constants shared by the polygon perimeter blocks
// ----------------------------------------------------------------------------
package ppdc_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int MIN_VERTICES = 3;
	localparam int COORD_BITS   = 16;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	localparam int DIFF_W       = COORD_BITS;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int SQ_W         = PROD_W + 1;
	localparam int FRAC_SHIFT   = 16;
	localparam int RAD_W        = ((SQ_W + FRAC_SHIFT + 1) / 2) * 2;
	localparam int ROOT_W       = RAD_W / 2;
	localparam int REM_W        = ROOT_W + 3;
	localparam int STEP_W       = $clog2(ROOT_W);
	localparam int PERIM_W      = 32;

	localparam int Q_DEPTH      = 4;
	localparam int Q_PTR_W      = $clog2(Q_DEPTH);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic                         last_point;
	} pt_t;

	typedef struct packed {
		logic               duplicate;
		logic               perimeter_valid;
		logic [PERIM_W-1:0] perimeter_q8;
		logic               saturated;
		logic               too_few;
		logic               store_overflow;
	} res_t;

	typedef struct packed {
		logic              dup;
		logic              last;
		logic              ovf;
		logic              too_few;
		logic              e1_en;
		logic [DIFF_W-1:0] dx1;
		logic [DIFF_W-1:0] dy1;
		logic [DIFF_W-1:0] dx2;
		logic [DIFF_W-1:0] dy2;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SEARCH,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SQ_A,
		B_SQ_B,
		B_ROOT,
		B_ADD,
		B_OUT
	} back_state_t;

endpackage

// ===== rtl/ppdc_front.sv =====
// ----------------------------------------------------------------------------
// ppdc_front
// takes vertices, searches the vertex store for duplicates, forms edge jobs
// ----------------------------------------------------------------------------
module ppdc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pt_valid,
	output logic             pt_stall,
	input  ppdc_pkg::pt_t    pt,
	output logic             q_push,
	output ppdc_pkg::job_t   q_job,
	input  logic             q_full
);

	ppdc_pkg::front_state_t state_q, state_nxt;

	logic signed [ppdc_pkg::COORD_BITS-1:0] x_q, y_q;
	logic                                   last_q;
	logic signed [ppdc_pkg::COORD_BITS-1:0] first_x_q, first_y_q;
	logic signed [ppdc_pkg::COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic [ppdc_pkg::CNT_W-1:0]             count_q, cnt_nxt;
	logic                                   ovf_q, ovf_nxt;
	logic                                   dup_q;
	logic [ppdc_pkg::CNT_W-1:0]             rd_idx_q;
	logic                                   cmp_vld_s1;
	logic [2*ppdc_pkg::COORD_BITS-1:0]      rd_data_s1;
	logic [2*ppdc_pkg::COORD_BITS-1:0]      mem [ppdc_pkg::MAX_VERTICES];

	logic                                   accept, issue, store_full, is_first;
	logic signed [ppdc_pkg::COORD_BITS-1:0] first_x_eff, first_y_eff;

	function automatic logic [ppdc_pkg::DIFF_W-1:0] abs_diff(
		input logic signed [ppdc_pkg::COORD_BITS-1:0] a,
		input logic signed [ppdc_pkg::COORD_BITS-1:0] b
	);
		logic signed [ppdc_pkg::COORD_BITS:0] d;
		d = $signed({a[ppdc_pkg::COORD_BITS-1], a}) - $signed({b[ppdc_pkg::COORD_BITS-1], b});
		if (d < 0) begin
			d = -d;
		end
		return d[ppdc_pkg::DIFF_W-1:0];
	endfunction

	assign pt_stall   = (state_q != ppdc_pkg::F_IDLE);
	assign accept     = pt_valid && !pt_stall;
	assign store_full = (count_q == ppdc_pkg::CNT_W'(ppdc_pkg::MAX_VERTICES));
	assign issue      = (state_q == ppdc_pkg::F_SEARCH) && !store_full && (rd_idx_q < count_q);
	assign is_first   = (count_q == '0) && !ovf_q;
	assign ovf_nxt    = ovf_q | store_full;
	assign cnt_nxt    = store_full ? count_q : count_q + ppdc_pkg::CNT_W'(1);
	assign first_x_eff = is_first ? x_q : first_x_q;
	assign first_y_eff = is_first ? y_q : first_y_q;

	always_comb begin
		q_job.dup     = dup_q;
		q_job.last    = last_q;
		q_job.ovf     = ovf_nxt;
		q_job.too_few = (cnt_nxt < ppdc_pkg::CNT_W'(ppdc_pkg::MIN_VERTICES)) && !ovf_nxt;
		q_job.e1_en   = !is_first;
		q_job.dx1     = abs_diff(prev_x_q, x_q);
		q_job.dy1     = abs_diff(prev_y_q, y_q);
		q_job.dx2     = abs_diff(x_q, first_x_eff);
		q_job.dy2     = abs_diff(y_q, first_y_eff);
	end

	always_comb begin
		state_nxt = state_q;
		q_push    = 1'b0;
		case (state_q)
			ppdc_pkg::F_IDLE: begin
				if (accept) begin
					state_nxt = ppdc_pkg::F_SEARCH;
				end
			end
			ppdc_pkg::F_SEARCH: begin
				if (!issue && !cmp_vld_s1) begin
					state_nxt = ppdc_pkg::F_PUSH;
				end
			end
			ppdc_pkg::F_PUSH: begin
				if (!q_full) begin
					q_push    = 1'b1;
					state_nxt = ppdc_pkg::F_IDLE;
				end
			end
			default: begin
				state_nxt = ppdc_pkg::F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppdc_pkg::F_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ovf_q      <= 1'b0;
			first_x_q  <= '0;
			first_y_q  <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			rd_idx_q   <= '0;
			dup_q      <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			if (accept) begin
				rd_idx_q <= '0;
				dup_q    <= 1'b0;
			end else begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + ppdc_pkg::CNT_W'(1);
				end
				if (cmp_vld_s1 && (rd_data_s1 == {x_q, y_q})) begin
					dup_q <= 1'b1;
				end
			end
			if (q_push) begin
				if (last_q) begin
					count_q   <= '0;
					ovf_q     <= 1'b0;
					first_x_q <= '0;
					first_y_q <= '0;
					prev_x_q  <= '0;
					prev_y_q  <= '0;
				end else begin
					count_q   <= cnt_nxt;
					ovf_q     <= ovf_nxt;
					first_x_q <= first_x_eff;
					first_y_q <= first_y_eff;
					prev_x_q  <= x_q;
					prev_y_q  <= y_q;
				end
			end
		end
	end

	// vertex payload
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= pt.point_x;
			y_q    <= pt.point_y;
			last_q <= pt.last_point;
		end
	end

	// vertex store
	always_ff @(posedge clk) begin
		if (q_push && !store_full) begin
			mem[count_q[ppdc_pkg::ADDR_W-1:0]] <= {x_q, y_q};
		end
		rd_data_s1 <= mem[rd_idx_q[ppdc_pkg::ADDR_W-1:0]];
	end

endmodule

// ===== rtl/ppdc_queue.sv =====
// ----------------------------------------------------------------------------
// ppdc_queue
// small job queue between the front and back parts
// ----------------------------------------------------------------------------
module ppdc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ppdc_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output ppdc_pkg::job_t pop_job,
	output logic           empty
);

	ppdc_pkg::job_t              slots [ppdc_pkg::Q_DEPTH];
	logic [ppdc_pkg::Q_PTR_W:0]  wr_ptr_q, rd_ptr_q;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[ppdc_pkg::Q_PTR_W] != rd_ptr_q[ppdc_pkg::Q_PTR_W]) &&
	               (wr_ptr_q[ppdc_pkg::Q_PTR_W-1:0] == rd_ptr_q[ppdc_pkg::Q_PTR_W-1:0]);
	assign pop_job = slots[rd_ptr_q[ppdc_pkg::Q_PTR_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + (ppdc_pkg::Q_PTR_W+1)'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + (ppdc_pkg::Q_PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slots[wr_ptr_q[ppdc_pkg::Q_PTR_W-1:0]] <= push_job;
		end
	end

endmodule

// ===== rtl/ppdc_back.sv =====
// ----------------------------------------------------------------------------
// ppdc_back
// squares, bit-serial square root and saturating perimeter accumulation
// ----------------------------------------------------------------------------
module ppdc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  ppdc_pkg::job_t q_job,
	output logic           q_pop,
	output logic           res_valid,
	input  logic           res_stall,
	output ppdc_pkg::res_t res
);

	ppdc_pkg::back_state_t state_q, state_nxt;

	ppdc_pkg::job_t                job_q;
	logic                          phase_q;
	logic [ppdc_pkg::DIFF_W-1:0]   dx_q, dy_q;
	logic [ppdc_pkg::PROD_W-1:0]   sq_q;
	logic [ppdc_pkg::RAD_W-1:0]    rad_q;
	logic [ppdc_pkg::REM_W-1:0]    rem_q;
	logic [ppdc_pkg::ROOT_W-1:0]   root_q;
	logic [ppdc_pkg::STEP_W-1:0]   step_q;
	logic [ppdc_pkg::PERIM_W-1:0]  sum_q;
	logic                          clip_q;
	logic                          res_valid_q;
	ppdc_pkg::res_t                res_q;

	logic [ppdc_pkg::PROD_W-1:0]   dx_sq, dy_sq;
	logic [ppdc_pkg::SQ_W-1:0]     d2;
	logic [ppdc_pkg::REM_W-1:0]    rem_shift, trial;
	logic                          fits;
	logic [ppdc_pkg::PERIM_W:0]    acc;
	logic                          out_free, root_done;

	assign dx_sq     = {ppdc_pkg::DIFF_W'(0), dx_q} * {ppdc_pkg::DIFF_W'(0), dx_q};
	assign dy_sq     = {ppdc_pkg::DIFF_W'(0), dy_q} * {ppdc_pkg::DIFF_W'(0), dy_q};
	assign d2        = {1'b0, sq_q} + {1'b0, dy_sq};
	assign rem_shift = {rem_q[ppdc_pkg::REM_W-3:0], rad_q[ppdc_pkg::RAD_W-1 -: 2]};
	assign trial     = ppdc_pkg::REM_W'({root_q, 2'b01});
	assign fits      = (rem_shift >= trial);
	assign acc       = {1'b0, sum_q} + (ppdc_pkg::PERIM_W+1)'(root_q);
	assign out_free  = !res_valid_q || !res_stall;
	assign root_done = (step_q == ppdc_pkg::STEP_W'(ppdc_pkg::ROOT_W - 1));

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		state_nxt = state_q;
		q_pop     = 1'b0;
		case (state_q)
			ppdc_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_job.e1_en || q_job.last) begin
						state_nxt = ppdc_pkg::B_SQ_A;
					end else begin
						state_nxt = ppdc_pkg::B_OUT;
					end
				end
			end
			ppdc_pkg::B_SQ_A: state_nxt = ppdc_pkg::B_SQ_B;
			ppdc_pkg::B_SQ_B: state_nxt = ppdc_pkg::B_ROOT;
			ppdc_pkg::B_ROOT: begin
				if (root_done) begin
					state_nxt = ppdc_pkg::B_ADD;
				end
			end
			ppdc_pkg::B_ADD: begin
				if (!phase_q && job_q.last) begin
					state_nxt = ppdc_pkg::B_SQ_A;
				end else begin
					state_nxt = ppdc_pkg::B_OUT;
				end
			end
			ppdc_pkg::B_OUT: begin
				if (out_free) begin
					state_nxt = ppdc_pkg::B_IDLE;
				end
			end
			default: begin
				state_nxt = ppdc_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppdc_pkg::B_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			clip_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ppdc_pkg::B_ADD) begin
				if (acc[ppdc_pkg::PERIM_W]) begin
					sum_q  <= '1;
					clip_q <= 1'b1;
				end else begin
					sum_q <= acc[ppdc_pkg::PERIM_W-1:0];
				end
			end
			if ((state_q == ppdc_pkg::B_OUT) && out_free) begin
				res_valid_q <= 1'b1;
				if (job_q.last) begin
					sum_q  <= '0;
					clip_q <= 1'b0;
				end
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ppdc_pkg::B_IDLE: begin
				job_q <= q_job;
				if (q_job.e1_en) begin
					phase_q <= 1'b0;
					dx_q    <= q_job.dx1;
					dy_q    <= q_job.dy1;
				end else begin
					phase_q <= 1'b1;
					dx_q    <= q_job.dx2;
					dy_q    <= q_job.dy2;
				end
			end
			ppdc_pkg::B_SQ_A: begin
				sq_q <= dx_sq;
			end
			ppdc_pkg::B_SQ_B: begin
				rad_q  <= ppdc_pkg::RAD_W'(d2) << ppdc_pkg::FRAC_SHIFT;
				rem_q  <= '0;
				root_q <= '0;
				step_q <= '0;
			end
			ppdc_pkg::B_ROOT: begin
				rad_q  <= rad_q << 2;
				step_q <= step_q + ppdc_pkg::STEP_W'(1);
				if (fits) begin
					rem_q  <= rem_shift - trial;
					root_q <= {root_q[ppdc_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_shift;
					root_q <= {root_q[ppdc_pkg::ROOT_W-2:0], 1'b0};
				end
			end
			ppdc_pkg::B_ADD: begin
				phase_q <= 1'b1;
				dx_q    <= job_q.dx2;
				dy_q    <= job_q.dy2;
			end
			ppdc_pkg::B_OUT: begin
				if (out_free) begin
					res_q.duplicate       <= job_q.dup;
					res_q.perimeter_valid <= job_q.last;
					res_q.perimeter_q8    <= job_q.last ? sum_q : '0;
					res_q.saturated       <= job_q.last && clip_q;
					res_q.too_few         <= job_q.last && job_q.too_few;
					res_q.store_overflow  <= job_q.ovf;
				end
			end
			default: begin
				step_q <= '0;
			end
		endcase
	end

endmodule

// ===== rtl/polygon_perimeter_with_duplicate_check_core.sv =====
// ----------------------------------------------------------------------------
// polygon_perimeter_with_duplicate_check_core
// vertex stream in, one result per vertex out, with perimeter on the last
// ----------------------------------------------------------------------------
// pt carries one vertex per transaction (x, y, last_point); res carries one
// result per vertex: duplicate flag, sticky store overflow and, on the last
// vertex, the closed perimeter in unsigned Q8 with saturated and too_few.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low.
// The front walks the vertex store one entry per cycle, comparing each stored
// vertex with the new one; it skips the walk when the store is full (32 entries).
// Per edge the back runs the square states B_SQ_A and B_SQ_B, 25 root steps
// and an accumulate step; it pops each job and loads the result register.
// An opening vertex has no edge, a middle one the edge from the previous one,
// and the last one the closing edge to the first as well. A 4-entry job
// queue lets the front run ahead of the back; the slower part sets the rate.
// Reset empties the store, the queue and the output register; no clearing
// pass is needed. While res is stalled the result register holds, the back
// waits, and the front keeps taking vertices until the queue fills.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polygon_perimeter_with_duplicate_check_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pt_valid,
	output logic           pt_stall,
	input  ppdc_pkg::pt_t  pt,
	output logic           res_valid,
	input  logic           res_stall,
	output ppdc_pkg::res_t res
);

	logic           q_push, q_full, q_pop, q_empty;
	ppdc_pkg::job_t push_job, pop_job;

	ppdc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_stall (pt_stall),
		.pt       (pt),
		.q_push   (q_push),
		.q_job    (push_job),
		.q_full   (q_full)
	);

	ppdc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	ppdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_job     (pop_job),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	`PPDC_ASSERT_IMP(a_push_not_full, q_push, !q_full, "push into full job queue")
	`PPDC_ASSERT_IMP(a_pop_not_empty, q_pop, !q_empty, "pop from empty job queue")
	`PPDC_ASSERT_IMP(a_partial_clean, res_valid && !res.perimeter_valid, (res.perimeter_q8 == '0) && !res.saturated && !res.too_few, "perimeter fields set on a non-final result")
	`PPDC_ASSERT(a_few_not_sat, !(res_valid && res.too_few && res.saturated), "short polygon reported as saturated")

endmodule
